/* hdl/assert_macros.svh */
// Assertion macros used by the video RAM port controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define VAPF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define VAPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VAPF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define VAPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/vapf_pkg.sv */
// Shared types, register offsets and address helpers of the video RAM port.
`timescale 1ns / 1ps
package vapf_pkg;

   localparam int STORE_WORDS_DEFAULT = 32768;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic [5:0] OFF_DISPLAY = 6'h00;
   localparam logic [5:0] OFF_MODE    = 6'h15;
   localparam logic [5:0] OFF_ADDR_LO = 6'h16;
   localparam logic [5:0] OFF_ADDR_HI = 6'h17;
   localparam logic [5:0] OFF_DATA_LO = 6'h18;
   localparam logic [5:0] OFF_DATA_HI = 6'h19;
   localparam logic [5:0] OFF_READ_LO = 6'h39;
   localparam logic [5:0] OFF_READ_HI = 6'h3a;

   localparam logic [1:0] MAP_NONE = 2'd0;
   localparam logic [1:0] MAP_ROT8 = 2'd1;
   localparam logic [1:0] MAP_ROT9 = 2'd2;
   localparam logic [1:0] MAP_ROT10 = 2'd3;

   localparam logic [7:0] STEP_SMALL = 8'd1;
   localparam logic [7:0] STEP_ROW   = 8'd32;
   localparam logic [7:0] STEP_BIG   = 8'd128;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic calc;
      logic exec;
      logic fill;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic fetch;
   } status_type;

   function automatic logic [7:0] step_of(input logic [1:0] code);
      logic [7:0] step;
      case (code)
         2'd0:    step = STEP_SMALL;
         2'd1:    step = STEP_ROW;
         default: step = STEP_BIG;
      endcase
      return step;
   endfunction

   // Rotate the low 8, 9 or 10 address bits left by three.
   function automatic logic [15:0] map_addr(input logic [15:0] a, input logic [1:0] mode);
      logic [15:0] m;
      case (mode)
         MAP_ROT8:  m = {a[15:8], a[4:0], a[7:5]};
         MAP_ROT9:  m = {a[15:9], a[5:0], a[8:6]};
         MAP_ROT10: m = {a[15:10], a[6:0], a[9:7]};
         default:   m = a;
      endcase
      return m;
   endfunction

endpackage

/* hdl/vapf_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vapf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/vapf_datapath.sv */
// Port registers, address mapping, store and read data path.
`timescale 1ns / 1ps
module vapf_datapath #(
   parameter int STORE_WORDS = vapf_pkg::STORE_WORDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_func,
   input  logic [5:0]           req_reg_offset,
   input  logic [7:0]           req_bus_data,
   input  logic                 req_active_lines,
   input  vapf_pkg::cmd_type    cmd,
   output vapf_pkg::status_type status,
   output logic [7:0]           rsp_read_data
);
   import vapf_pkg::*;

   localparam int IDX_W = $clog2(STORE_WORDS);
   localparam int RED_STEPS = 17 - IDX_W;
   localparam logic [17:0] DIVISOR = 18'(STORE_WORDS);

   logic             func_ff;
   logic [5:0]       off_ff;
   logic [7:0]       data_ff;
   logic             active_ff;
   logic [7:0]       result_ff;
   logic [7:0]       rsp_data_ff;
   logic [15:0]      addr_ff;
   logic [15:0]      addr_in;
   logic [7:0]       step_ff;
   logic [1:0]       map_ff;
   logic             aoh_ff;
   logic             display_off_ff;
   logic [15:0]      prefetch_ff;
   logic             zero_fill_ff;
   logic [IDX_W-1:0] index_ff;
   logic [17:0]      reduced;
   logic             blocked;
   logic             lo_we;
   logic             hi_we;
   logic             advance;
   logic             fetch;
   logic [7:0]       lo_rdata;
   logic [7:0]       hi_rdata;

   // Reduce the mapped address modulo the store depth.
   always_comb begin
      reduced = {2'b00, map_addr(addr_ff, map_ff)};
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (reduced >= (DIVISOR << k)) begin
            reduced = reduced - (DIVISOR << k);
         end
      end
   end

   assign blocked = !display_off_ff && active_ff;

   always_comb begin
      lo_we = 1'b0;
      hi_we = 1'b0;
      advance = 1'b0;
      fetch = 1'b0;
      if (func_ff == FUNC_WRITE) begin
         case (off_ff)
            OFF_ADDR_LO, OFF_ADDR_HI: begin
               fetch = 1'b1;
            end
            OFF_DATA_LO: begin
               lo_we = !blocked;
               advance = !aoh_ff;
            end
            OFF_DATA_HI: begin
               hi_we = !blocked;
               advance = aoh_ff;
            end
            default: begin
            end
         endcase
      end else begin
         case (off_ff)
            OFF_READ_LO: begin
               fetch = !aoh_ff;
               advance = !aoh_ff;
            end
            OFF_READ_HI: begin
               fetch = aoh_ff;
               advance = aoh_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign status.fetch = fetch;

   always_comb begin
      addr_in = addr_ff;
      if (cmd.capture && req_func == FUNC_WRITE) begin
         if (req_reg_offset == OFF_ADDR_LO) begin
            addr_in = {addr_ff[15:8], req_bus_data};
         end else if (req_reg_offset == OFF_ADDR_HI) begin
            addr_in = {req_bus_data, addr_ff[7:0]};
         end
      end else if (cmd.exec && advance) begin
         addr_in = addr_ff + {8'h00, step_ff};
      end
   end

   // Architectural port registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         step_ff <= STEP_SMALL;
         map_ff <= MAP_NONE;
         aoh_ff <= 1'b0;
         display_off_ff <= 1'b1;
         prefetch_ff <= '0;
      end else begin
         addr_ff <= addr_in;
         if (cmd.capture && req_func == FUNC_WRITE) begin
            if (req_reg_offset == OFF_DISPLAY) begin
               display_off_ff <= req_bus_data[7];
            end
            if (req_reg_offset == OFF_MODE) begin
               step_ff <= step_of(req_bus_data[1:0]);
               map_ff <= req_bus_data[3:2];
               aoh_ff <= req_bus_data[7];
            end
         end
         if (cmd.fill) begin
            prefetch_ff <= zero_fill_ff ? 16'h0000 : {hi_rdata, lo_rdata};
         end
      end
   end

   // Request payload and result staging.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         off_ff <= req_reg_offset;
         data_ff <= req_bus_data;
         active_ff <= req_active_lines;
         if (req_func == FUNC_WRITE) begin
            result_ff <= 8'h00;
         end else if (req_reg_offset == OFF_READ_LO) begin
            result_ff <= prefetch_ff[7:0];
         end else if (req_reg_offset == OFF_READ_HI) begin
            result_ff <= prefetch_ff[15:8];
         end else begin
            result_ff <= req_bus_data;
         end
      end
      if (cmd.calc) begin
         index_ff <= reduced[IDX_W-1:0];
      end
      if (cmd.exec) begin
         zero_fill_ff <= blocked;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= result_ff;
      end
   end

   vapf_ram #(
      .WIDTH(8),
      .DEPTH(STORE_WORDS)
   ) u_ram_lo (
      .clock(clock),
      .we   (cmd.exec && lo_we),
      .addr (index_ff),
      .wdata(data_ff),
      .rdata(lo_rdata)
   );

   vapf_ram #(
      .WIDTH(8),
      .DEPTH(STORE_WORDS)
   ) u_ram_hi (
      .clock(clock),
      .we   (cmd.exec && hi_we),
      .addr (index_ff),
      .wdata(data_ff),
      .rdata(hi_rdata)
   );

   assign rsp_read_data = rsp_data_ff;

endmodule

/* hdl/vapf_ctrl.sv */
// Sequencing state machine and result handshake of the video RAM port.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vapf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  vapf_pkg::status_type status,
   output vapf_pkg::cmd_type    cmd
);
   import vapf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAP,
      S_EXEC,
      S_FILL,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.calc = (state_ff == S_MAP);
      cmd.exec = (state_ff == S_EXEC);
      cmd.fill = (state_ff == S_FILL);
      cmd.load_rsp = (state_ff == S_DONE) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the valid flag unless a new result takes the slot right away.
         if (rsp_valid_ff && rsp_ready && !cmd.load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_MAP;
               end
            end
            S_MAP: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= status.fetch ? S_FILL : S_DONE;
            end
            S_FILL: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // Hold until the output register can take the result.
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `VAPF_ASSERT_NEXT(a_accept_maps, clock, reset, req_valid && req_ready, state_ff == S_MAP, "accepted request did not enter address mapping")
   `VAPF_ASSERT_IMPL(a_fill_after_exec, clock, reset, state_ff == S_FILL, $past(state_ff) == S_EXEC, "refetch capture without a preceding store access")
   `VAPF_ASSERT_NEXT(a_result_shown, clock, reset, cmd.load_rsp, rsp_valid_ff, "loaded result not presented")
   `VAPF_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.load_rsp && rsp_valid_ff, rsp_ready, "pending result overwritten")

endmodule

/* hdl/vram_access_port_with_prefetch.sv */
// Top level of the byte-wide video RAM access port with read prefetch.
//
// Request channel (req_*): one bus access per request: req_func selects
// read or write, req_reg_offset the register, req_bus_data the write byte
// (or open-bus byte), req_active_lines whether the beam is in active lines.
// Response channel (rsp_*): exactly one byte per request, in order; writes
// return zero, reads of unhandled registers return the open-bus byte.
// A request is taken only while the port is idle; it then passes through
// address mapping, store access and output load, with a refetch step
// before the output load when it refetches the prefetch word, since the
// store read data is registered and captured in a step of its own. The
// response appears in the output register after the output load. The store
// is one word-wide port split into two byte RAMs; the mapped address is
// reduced modulo the store depth in a registered step before the access.
// Synchronous reset returns the address, mode and prefetch registers to
// their defaults and empties the output register; store contents are not
// cleared. While the receiver stalls, a finished response waits in the
// output register; the next request is still taken and runs up to its
// final load step, where it holds until the output register frees.
`timescale 1ns / 1ps
module vram_access_port_with_prefetch #(
   parameter int STORE_WORDS = vapf_pkg::STORE_WORDS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [5:0] req_reg_offset,
   input  logic [7:0] req_bus_data,
   input  logic       req_active_lines,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);
   import vapf_pkg::*;

   cmd_type    cmd;
   status_type status;

   vapf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   vapf_datapath #(
      .STORE_WORDS(STORE_WORDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_reg_offset  (req_reg_offset),
      .req_bus_data    (req_bus_data),
      .req_active_lines(req_active_lines),
      .cmd             (cmd),
      .status          (status),
      .rsp_read_data   (rsp_read_data)
   );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the byte-wide video RAM port with read prefetch.
`timescale 1ns / 1ps
module tb;
   import vapf_pkg::*;

   localparam int          STORE_WORDS    = STORE_WORDS_DEFAULT;
   localparam logic [5:0]  OFF_UNUSED_TOP = 6'h3f;
   localparam int          RESET_CYCLES   = 9;
   localparam int          FILL_WORDS     = 64;
   localparam int          RANDOM_ITEMS   = 1500;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          MAX_GAP        = 30;
   localparam int          DRAIN_CYCLES   = 20;
   localparam int unsigned CYCLE_LIMIT    = 2_500_000;

   // Tracks port state request by request and holds the bytes still owed.
   class vram_port_predictor;
      logic [15:0] store [STORE_WORDS];
      bit   [15:0] word_addr;
      bit   [7:0]  step;
      bit   [1:0]  mapping;
      bit          adv_high;
      logic [15:0] prefetch;
      bit          disp_off;
      bit   [7:0]  step_by_code [4];
      logic [7:0]  expected_read_bytes [$];
      int          mismatches;
      int          n_effective;
      int          n_checked;
      int          n_blocked;
      int          n_refetch;

      function new();
         step_by_code = '{STEP_SMALL, STEP_ROW, STEP_BIG, STEP_BIG};
         word_addr    = 16'h0000;
         step         = STEP_SMALL;
         mapping      = MAP_NONE;
         adv_high     = 1'b0;
         prefetch     = 16'h0000;
         disp_off     = 1'b1;
      endfunction

      function bit blocked(logic active);
         return !disp_off && active;
      endfunction

      function int unsigned store_index();
         bit [15:0] a;
         bit [15:0] m;
         a = word_addr;
         case (mapping)
            MAP_ROT8:  m = (a & 16'hff00) | ((a & 16'h001f) << 3) | ((a >> 5) & 16'h7);
            MAP_ROT9:  m = (a & 16'hfe00) | ((a & 16'h003f) << 3) | ((a >> 6) & 16'h7);
            MAP_ROT10: m = (a & 16'hfc00) | ((a & 16'h007f) << 3) | ((a >> 7) & 16'h7);
            default:   m = a;
         endcase
         return int'(m) % STORE_WORDS;
      endfunction

      function void refetch(logic active);
         n_refetch++;
         if (blocked(active)) prefetch = 16'h0000;
         else prefetch = store[store_index()];
      endfunction

      function void note_request(logic func, logic [5:0] off, logic [7:0] data,
                                 logic active);
         logic [7:0] rsp;
         int unsigned i;
         rsp = 8'h00;
         n_effective++;
         if (blocked(active)) n_blocked++;
         if (func == FUNC_WRITE) begin
            case (off)
               OFF_DISPLAY: disp_off = data[7];
               OFF_MODE: begin
                  step     = step_by_code[data[1:0]];
                  mapping  = data[3:2];
                  adv_high = data[7];
               end
               OFF_ADDR_LO: begin
                  word_addr[7:0] = data;
                  refetch(active);
               end
               OFF_ADDR_HI: begin
                  word_addr[15:8] = data;
                  refetch(active);
               end
               OFF_DATA_LO: begin
                  if (!blocked(active)) begin
                     i = store_index();
                     store[i][7:0] = data;
                  end
                  if (!adv_high) word_addr = word_addr + step;
               end
               OFF_DATA_HI: begin
                  if (!blocked(active)) begin
                     i = store_index();
                     store[i][15:8] = data;
                  end
                  if (adv_high) word_addr = word_addr + step;
               end
               default: n_effective--;
            endcase
         end else begin
            case (off)
               OFF_READ_LO: begin
                  rsp = prefetch[7:0];
                  if (!adv_high) begin
                     refetch(active);
                     word_addr = word_addr + step;
                  end
               end
               OFF_READ_HI: begin
                  rsp = prefetch[15:8];
                  if (adv_high) begin
                     refetch(active);
                     word_addr = word_addr + step;
                  end
               end
               default: rsp = data;
            endcase
         end
         expected_read_bytes.push_back(rsp);
      endfunction

      function void check_response(logic [7:0] got);
         logic [7:0] want;
         if (expected_read_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response %02h arrived with none expected", $realtime, got);
         end else begin
            want = expected_read_bytes.pop_front();
            n_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: read_data mismatch on response %0d: expected %02h, got %02h",
                           $realtime, n_checked, want, got);
            end
         end
      endfunction

      function int pending();
         return expected_read_bytes.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_func;
   logic [5:0] req_reg_offset;
   logic [7:0] req_bus_data;
   logic       req_active_lines;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;

   vram_port_predictor sb;
   int          sender_idle_pct;
   int          recv_idle_pct;
   logic        hold_trigger;
   bit          hold_started = 1'b0;
   int          hold_left = 0;
   int unsigned cycles;
   logic [15:0] last_write_target = 16'h0000;

   vram_access_port_with_prefetch i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_reg_offset   (req_reg_offset),
      .req_bus_data     (req_bus_data),
      .req_active_lines (req_active_lines),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data)
   );

   always #2 clock = ~clock;

   // Receiver: random stalls, plus one long hold-off to back the port up.
   always @(posedge clock) begin
      if (hold_trigger && !hold_started) begin
         hold_started = 1'b1;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_read_data);
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d responses still owed", cycles, sb.pending());
      $display("Mismatches found");
      $finish;
   end

   function automatic logic pick_active();
      return $urandom_range(99) < 35;
   endfunction

   task automatic send_request(input logic func, input logic [5:0] off,
                               input logic [7:0] data, input logic active);
      int gap;
      gap = 0;
      // steer away from bytes of words that were never written
      if (func == FUNC_READ &&
          ((off == OFF_READ_LO && $isunknown(sb.prefetch[7:0])) ||
           (off == OFF_READ_HI && $isunknown(sb.prefetch[15:8]))))
         off = OFF_UNUSED_TOP;
      while (sender_idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_reg_offset   <= off;
      req_bus_data     <= data;
      req_active_lines <= active;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, off, data, active);
   endtask

   // One data access, mostly as a low/high pair, sometimes a lone byte.
   task automatic data_access(input logic func);
      logic [5:0] lo;
      logic [5:0] hi;
      lo = (func == FUNC_WRITE) ? OFF_DATA_LO : OFF_READ_LO;
      hi = (func == FUNC_WRITE) ? OFF_DATA_HI : OFF_READ_HI;
      if ($urandom_range(3) != 0) begin
         send_request(func, lo, 8'($urandom()), pick_active());
         send_request(func, hi, 8'($urandom()), pick_active());
      end else begin
         send_request(func, $urandom_range(1) ? hi : lo, 8'($urandom()), pick_active());
      end
   endtask

   task automatic random_burst();
      int          pick;
      int          count;
      logic [15:0] target;
      pick   = $urandom_range(99);
      count  = $urandom_range(1, 8);
      target = 16'($urandom());
      if (pick < 8) begin
         send_request(FUNC_WRITE, OFF_MODE, 8'($urandom()), pick_active());
      end else if (pick < 14) begin
         // keep the display off more often than not so blocking stays occasional
         send_request(FUNC_WRITE, OFF_DISPLAY, {($urandom_range(99) < 60), 7'($urandom())},
                      pick_active());
      end else if (pick < 85) begin
         // read bursts mostly revisit the words of the last write burst
         if (pick < 50) last_write_target = target;
         else if ($urandom_range(3) != 0) target = last_write_target;
         if ($urandom_range(3) != 0) begin
            send_request(FUNC_WRITE, OFF_ADDR_LO, target[7:0], pick_active());
            send_request(FUNC_WRITE, OFF_ADDR_HI, target[15:8], pick_active());
         end else begin
            send_request(FUNC_WRITE, $urandom_range(1) ? OFF_ADDR_HI : OFF_ADDR_LO,
                         target[7:0], pick_active());
         end
         repeat (count) data_access((pick < 50) ? FUNC_WRITE : FUNC_READ);
      end else begin
         send_request(1'($urandom()), 6'($urandom()), 8'($urandom()), pick_active());
      end
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_READ;
      req_reg_offset   = OFF_DISPLAY;
      req_bus_data     = 8'h00;
      req_active_lines = 1'b0;
      hold_trigger     = 1'b0;
      sender_idle_pct  = 0;
      recv_idle_pct    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the first words straight from reset (step 1, advance on low byte).
      for (int w = 0; w < FILL_WORDS; w++) begin
         send_request(FUNC_WRITE, OFF_DATA_HI, 8'($urandom()), pick_active());
         send_request(FUNC_WRITE, OFF_DATA_LO, 8'($urandom()), pick_active());
      end

      sender_idle_pct = 33;
      recv_idle_pct  <= 81;
      // open bus and ignored offsets
      send_request(FUNC_READ,  OFF_DISPLAY,    8'hA5, 1'b0);
      send_request(FUNC_READ,  OFF_UNUSED_TOP, 8'hFF, 1'b1);
      send_request(FUNC_WRITE, OFF_UNUSED_TOP, 8'hFF, 1'b0);
      // widest step, widest rotation, advance on high; address wraps past 0xffff
      send_request(FUNC_WRITE, OFF_MODE,    8'h8F, 1'b0);
      send_request(FUNC_WRITE, OFF_ADDR_LO, 8'hFF, 1'b0);
      send_request(FUNC_WRITE, OFF_ADDR_HI, 8'hFF, 1'b0);
      send_request(FUNC_WRITE, OFF_DATA_LO, 8'h00, 1'b0);
      send_request(FUNC_WRITE, OFF_DATA_HI, 8'hFF, 1'b0);
      send_request(FUNC_WRITE, OFF_ADDR_LO, 8'hFF, 1'b0);
      send_request(FUNC_WRITE, OFF_ADDR_HI, 8'hFF, 1'b0);
      send_request(FUNC_READ,  OFF_READ_LO, 8'h00, 1'b0);
      send_request(FUNC_READ,  OFF_READ_HI, 8'hFF, 1'b0);
      send_request(FUNC_WRITE, OFF_MODE,    8'h05, 1'b0);
      send_request(FUNC_WRITE, OFF_ADDR_HI, 8'h00, 1'b0);
      send_request(FUNC_WRITE, OFF_ADDR_LO, 8'h00, 1'b0);
      send_request(FUNC_READ,  OFF_READ_HI, 8'h00, 1'b0);
      send_request(FUNC_READ,  OFF_READ_LO, 8'h00, 1'b0);
      send_request(FUNC_WRITE, OFF_MODE,    8'h0A, 1'b0);
      send_request(FUNC_WRITE, OFF_DATA_LO, 8'h5A, 1'b0);
      // display on during active lines: drop writes, zero the prefetch, still advance
      send_request(FUNC_WRITE, OFF_DISPLAY, 8'h00, 1'b0);
      send_request(FUNC_WRITE, OFF_DATA_HI, 8'hC3, 1'b1);
      send_request(FUNC_WRITE, OFF_DATA_LO, 8'h3C, 1'b1);
      send_request(FUNC_WRITE, OFF_ADDR_LO, 8'h10, 1'b1);
      send_request(FUNC_READ,  OFF_READ_LO, 8'hFF, 1'b1);
      send_request(FUNC_READ,  OFF_READ_LO, 8'hFF, 1'b0);
      send_request(FUNC_WRITE, OFF_DISPLAY, 8'h80, 1'b1);
      send_request(FUNC_WRITE, OFF_MODE,    8'h00, 1'b0);

      begin
         int base;
         base = sb.n_effective;
         while (sb.n_effective < base + RANDOM_ITEMS / 3) random_burst();
         sender_idle_pct = 81;
         recv_idle_pct  <= 33;
         while (sb.n_effective < base + 2 * RANDOM_ITEMS / 3) random_burst();
         sender_idle_pct = 0;
         recv_idle_pct  <= 0;
         // long receiver hold-off while requests keep coming
         hold_trigger <= 1'b1;
         while (sb.n_effective < base + RANDOM_ITEMS) random_burst();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests with %0d checked responses, %0d prefetch loads and %0d",
               sb.n_effective, sb.n_checked, sb.n_refetch, sb.n_blocked);
      $display("blocked accesses across all modes, address wrap and three stall mixes.");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
